// File: hdl/lwkr_pkg.sv
// ----------------------------------------------------------------------------
// lwkr_pkg
// Shared constants and types for the longest-window letter replacement block.
// ----------------------------------------------------------------------------
package lwkr_pkg;

   localparam int MAX_LEN  = 256;
   localparam int ALPHABET = 26;

   localparam int LETTER_W = 7;
   localparam int BUDGET_W = 9;
   localparam int BEST_W   = 9;
   localparam int SYM_W    = 5;

   localparam int IDX_W  = (MAX_LEN > 2) ? $clog2(MAX_LEN) : 1;
   localparam int LEN_W  = $clog2(MAX_LEN + 1);
   localparam int GROW_W = LEN_W + 1;
   localparam int SUM_W  = LEN_W + 1;
   localparam int CMP_W  = (GROW_W > BUDGET_W) ? GROW_W : BUDGET_W;

   localparam logic [LETTER_W-1:0] LETTER_FIRST = 7'd65;  // 'A'
   localparam logic [LETTER_W-1:0] LETTER_LAST  = 7'd90;  // 'Z'

   typedef logic [SYM_W-1:0]  sym_type;
   typedef logic [IDX_W-1:0]  idx_type;
   typedef logic [LEN_W-1:0]  len_type;
   typedef logic [GROW_W-1:0] grow_type;

   typedef struct packed {
      logic    we;
      idx_type waddr;
      sym_type wdata;
      idx_type raddr;
   } ring_req_type;

   typedef struct packed {
      logic [BEST_W-1:0] best_len;
      logic              final_res;
   } result_type;

endpackage

// File: hdl/lwkr_ring_ram.sv
// ----------------------------------------------------------------------------
// lwkr_ring_ram
// Ring of window letters: one write and one registered read per cycle,
// write-first on a same-address collision.
// ----------------------------------------------------------------------------
module lwkr_ring_ram import lwkr_pkg::*; (
   input  logic         clock,
   input  ring_req_type ring_req,
   output sym_type      rd_data
);

   sym_type ring_mem [MAX_LEN];
   sym_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (ring_req.we) begin
         ring_mem[ring_req.waddr] <= ring_req.wdata;
      end
      if (ring_req.we && (ring_req.waddr == ring_req.raddr)) begin
         rd_data_ff <= ring_req.wdata;
      end else begin
         rd_data_ff <= ring_mem[ring_req.raddr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hdl/lwkr_core.sv
// ----------------------------------------------------------------------------
// lwkr_core
// Letter counts, window bookkeeping and the slide decision for one beat.
// The ring read port always points at the oldest letter of the next cycle.
// ----------------------------------------------------------------------------
module lwkr_core import lwkr_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                go,
   input  logic [LETTER_W-1:0] letter,
   input  logic                last,
   input  logic                csr_wr_en,
   input  logic [BUDGET_W-1:0] csr_wr_data,
   input  sym_type             oldest,
   output ring_req_type        ring_req,
   output result_type          result
);

   logic [BUDGET_W-1:0] budget_ff, budget_in;
   len_type  counts_ff [ALPHABET];
   len_type  counts_in [ALPHABET];
   idx_type  start_ff, start_in;
   len_type  len_ff, len_in;
   grow_type top_ff, top_in;
   len_type  best_ff, best_in;

   logic       is_letter;
   sym_type    sym;
   sym_type    old_sym;
   grow_type   new_cnt;
   grow_type   code_cnt;
   grow_type   top_new;
   grow_type   grown;
   grow_type   spare;
   logic       evict;
   len_type    len_new;
   len_type    best_new;
   idx_type    start_adv;
   logic [SUM_W-1:0] slot_sum;
   idx_type    slot;

   always_comb begin
      is_letter = (letter >= LETTER_FIRST) && (letter <= LETTER_LAST);
      sym       = is_letter ? SYM_W'(letter - LETTER_FIRST) : '0;
      old_sym   = (oldest < SYM_W'(ALPHABET)) ? oldest : '0;

      new_cnt = GROW_W'(counts_ff[sym]) + 1'b1;
      top_new = (new_cnt > top_ff) ? new_cnt : top_ff;
      grown   = GROW_W'(len_ff) + 1'b1;
      spare   = grown - top_new;
      // full ring forces a slide; otherwise slide when too many letters differ
      evict   = is_letter &&
                ((grown > GROW_W'(MAX_LEN)) ||
                 ((grown > top_new) && (CMP_W'(spare) > CMP_W'(budget_ff))));
      len_new  = evict ? len_ff : LEN_W'(grown);
      best_new = (is_letter && (len_new > best_ff)) ? len_new : best_ff;

      start_adv = (start_ff == IDX_W'(MAX_LEN - 1)) ? '0 : start_ff + 1'b1;
      slot_sum  = SUM_W'(start_ff) + SUM_W'(len_ff);
      slot      = (slot_sum >= SUM_W'(MAX_LEN)) ? IDX_W'(slot_sum - SUM_W'(MAX_LEN))
                                                 : IDX_W'(slot_sum);

      code_cnt = (evict && (old_sym == sym)) ? new_cnt - 1'b1 : new_cnt;

      budget_in = csr_wr_en ? csr_wr_data : budget_ff;
      counts_in = counts_ff;
      start_in  = start_ff;
      len_in    = len_ff;
      top_in    = top_ff;
      best_in   = best_ff;

      if (go) begin
         if (last) begin
            counts_in = '{default: '0};
            start_in  = '0;
            len_in    = '0;
            top_in    = '0;
            best_in   = '0;
         end else if (is_letter) begin
            counts_in[sym] = LEN_W'(code_cnt);
            if (evict && (old_sym != sym) && (counts_ff[old_sym] != '0)) begin
               counts_in[old_sym] = counts_ff[old_sym] - 1'b1;
            end
            start_in = evict ? start_adv : start_ff;
            len_in   = len_new;
            top_in   = top_new;
            best_in  = best_new;
         end
      end

      ring_req.we    = go && is_letter;
      ring_req.waddr = slot;
      ring_req.wdata = sym;
      ring_req.raddr = start_in;

      result.best_len  = BEST_W'(best_new);
      result.final_res = last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         budget_ff <= '0;
         counts_ff <= '{default: '0};
         start_ff  <= '0;
         len_ff    <= '0;
         top_ff    <= '0;
         best_ff   <= '0;
      end else begin
         budget_ff <= budget_in;
         counts_ff <= counts_in;
         start_ff  <= start_in;
         len_ff    <= len_in;
         top_ff    <= top_in;
         best_ff   <= best_in;
      end
   end

`ifndef SYNTHESIS
   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      len_ff <= LEN_W'(MAX_LEN))
      else $error("window length beyond ring depth");

   a_best_covers_len: assert property (@(posedge clock) disable iff (reset)
      best_ff >= len_ff)
      else $error("best length below current window");

   a_clear_on_last: assert property (@(posedge clock) disable iff (reset)
      go && last |=> (len_ff == '0) && (best_ff == '0) && (top_ff == '0)
                     && (start_ff == '0))
      else $error("string state not cleared after last beat");

   a_grow_by_one: assert property (@(posedge clock) disable iff (reset)
      go && !last |=> (len_ff == $past(len_ff)) || (len_ff == $past(len_ff) + 1'b1))
      else $error("window length jumped");

   a_idle_holds: assert property (@(posedge clock) disable iff (reset)
      !go |=> $stable(len_ff) && $stable(start_ff) && $stable(best_ff))
      else $error("state moved without a beat");
`endif

endmodule

// File: hdl/lwkr_out_skid.sv
// ----------------------------------------------------------------------------
// lwkr_out_skid
// Two-entry result buffer: output register plus a skid slot, so a new beat
// is taken while the previous result is still held.
// ----------------------------------------------------------------------------
module lwkr_out_skid import lwkr_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  result_type push_data,
   output logic       full,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output result_type rsp_data
);

   logic       main_valid_ff, main_valid_in;
   result_type main_ff, main_in;
   logic       spare_valid_ff, spare_valid_in;
   result_type spare_ff, spare_in;
   logic       pop;

   always_comb begin
      pop            = main_valid_ff && !rsp_stall;
      main_valid_in  = main_valid_ff;
      main_in        = main_ff;
      spare_valid_in = spare_valid_ff;
      spare_in       = spare_ff;

      if (pop) begin
         if (spare_valid_ff) begin
            main_in        = spare_ff;
            spare_valid_in = 1'b0;
         end else begin
            main_valid_in = 1'b0;
         end
      end
      if (push) begin
         if (!main_valid_in) begin
            main_valid_in = 1'b1;
            main_in       = push_data;
         end else begin
            spare_valid_in = 1'b1;
            spare_in       = push_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff  <= 1'b0;
         spare_valid_ff <= 1'b0;
      end else begin
         main_valid_ff  <= main_valid_in;
         spare_valid_ff <= spare_valid_in;
      end
      main_ff  <= main_in;
      spare_ff <= spare_in;
   end

   assign full      = spare_valid_ff;
   assign rsp_valid = main_valid_ff;
   assign rsp_data  = main_ff;

endmodule

// File: hdl/longest_window_k_replace_sliding.sv
// Each accepted letter beat's result is registered in the output buffer behind rsp_.
// One letter per cycle while not stalled; counts and window registers update on accept.
// The ring read port prefetches the oldest letter, so a slide does not wait for a ring read.
// req_stall rises only while both entries of the output buffer are occupied.
// Reset clears all string state and the replace budget at once; no clearing pass.
// ----------------------------------------------------------------------------
// longest_window_k_replace_sliding
// Longest run that can be made uniform with a bounded number of letter
// replacements, tracked over a letter stream with a sliding window.
// ----------------------------------------------------------------------------
module longest_window_k_replace_sliding import lwkr_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [LETTER_W-1:0] req_letter,
   input  logic                req_last,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [BEST_W-1:0]   rsp_best_len,
   output logic                rsp_final_res,
   input  logic                csr_wr_en,
   input  logic [BUDGET_W-1:0] csr_wr_data
);

   logic         go;
   logic         buf_full;
   sym_type      oldest;
   ring_req_type ring_req;
   result_type   result;
   result_type   rsp_data;

   assign req_stall = buf_full;
   assign go        = req_valid && !buf_full;

   lwkr_ring_ram u_ring (
      .clock    (clock),
      .ring_req (ring_req),
      .rd_data  (oldest)
   );

   lwkr_core u_core (
      .clock       (clock),
      .reset       (reset),
      .go          (go),
      .letter      (req_letter),
      .last        (req_last),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .oldest      (oldest),
      .ring_req    (ring_req),
      .result      (result)
   );

   lwkr_out_skid u_skid (
      .clock     (clock),
      .reset     (reset),
      .push      (go),
      .push_data (result),
      .full      (buf_full),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   assign rsp_best_len  = rsp_data.best_len;
   assign rsp_final_res = rsp_data.final_res;

endmodule

// File: test/lwkr_checker.sv
// ----------------------------------------------------------------------------
// lwkr_checker
// Watches the letter and result channels of the longest-window block. It keeps
// its own window model, queues the best length owed for each letter beat and
// compares every result beat against the oldest entry.
// ----------------------------------------------------------------------------
module lwkr_checker import lwkr_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_stall,
   input  logic [LETTER_W-1:0] req_letter,
   input  logic                req_last,
   input  logic                rsp_valid,
   input  logic                rsp_stall,
   input  logic [BEST_W-1:0]   rsp_best_len,
   input  logic                rsp_final_res,
   input  logic                csr_wr_en,
   input  logic [BUDGET_W-1:0] csr_wr_data,
   output int                  mismatch_count,
   output int                  results_owed
);

   logic [BUDGET_W-1:0] budget;
   int                  letter_count [ALPHABET];
   sym_type             ring [MAX_LEN];
   idx_type             head;
   int                  win_len;
   int                  peak_count;
   int                  best_so_far;
   result_type          owed_q [$];
   int                  errors;

   initial begin
      mismatch_count = 0;
      results_owed   = 0;
      errors         = 0;
   end

   task automatic clear_string();
      for (int i = 0; i < ALPHABET; i++) letter_count[i] = 0;
      for (int i = 0; i < MAX_LEN; i++) ring[i] = '0;
      head        = '0;
      win_len     = 0;
      peak_count  = 0;
      best_so_far = 0;
   endtask

   // Window grows by one or slides by one; the peak never drops, so the window never shrinks.
   task automatic slide_in(input sym_type s);
      sym_type oldest;
      int      grown;
      oldest = ring[head];  // read before the write: a full ring reuses this slot
      grown  = win_len + 1;
      ring[(int'(head) + win_len) % MAX_LEN] = s;
      letter_count[s]++;
      if (letter_count[s] > peak_count) peak_count = letter_count[s];
      if (grown > MAX_LEN || (grown > peak_count && grown - peak_count > int'(budget))) begin
         if (letter_count[oldest] > 0) letter_count[oldest]--;
         head = idx_type'((int'(head) + 1) % MAX_LEN);
         grown--;
      end
      win_len = grown;
      if (win_len > best_so_far) best_so_far = win_len;
   endtask

   always @(posedge clock) begin
      result_type want;
      if (reset) begin
         budget = '0;
         clear_string();
         owed_q.delete();
         errors = 0;
      end else begin
         if (csr_wr_en) budget = csr_wr_data;
         if (rsp_valid && !rsp_stall) begin
            if (owed_q.size() == 0) begin
               $error("result beat with nothing owed: best_len %0d", rsp_best_len);
               errors++;
            end else begin
               want = owed_q.pop_front();
               if (rsp_best_len !== want.best_len) begin
                  $error("best_len mismatch: expected %0d, got %0d",
                         want.best_len, rsp_best_len);
                  errors++;
               end
               if (rsp_final_res !== want.final_res) begin
                  $error("final_res mismatch: expected %0d, got %0d",
                         want.final_res, rsp_final_res);
                  errors++;
               end
            end
         end
         if (req_valid && !req_stall) begin
            // codes outside A..Z leave the window untouched
            if (req_letter >= LETTER_FIRST && req_letter <= LETTER_LAST)
               slide_in(sym_type'(req_letter - LETTER_FIRST));
            want.best_len  = BEST_W'(best_so_far);
            want.final_res = req_last;
            owed_q.push_back(want);
            if (req_last) clear_string();
         end
      end
      mismatch_count <= errors;
      results_owed   <= owed_q.size();
   end

endmodule

// File: test/tb.sv
// ----------------------------------------------------------------------------
// tb
// Drives letter strings into the longest-window block under several replace
// budgets: short directed strings, a string that overruns the window ring,
// and random strings over small and full alphabets with stray codes. Sender bursts and
// receiver stalls are random; the checker beside the block scores results.
// ----------------------------------------------------------------------------
module tb;
   import lwkr_pkg::*;

   localparam logic [LETTER_W-1:0] CODE_A = LETTER_FIRST;
   localparam logic [LETTER_W-1:0] CODE_B = LETTER_FIRST + 7'd1;
   localparam logic [LETTER_W-1:0] CODE_C = LETTER_FIRST + 7'd2;
   localparam logic [LETTER_W-1:0] CODE_Z = LETTER_LAST;

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_stall;
   logic [LETTER_W-1:0] req_letter;
   logic                req_last;
   logic                rsp_valid;
   logic                rsp_stall;
   logic [BEST_W-1:0]   rsp_best_len;
   logic                rsp_final_res;
   logic                csr_wr_en;
   logic [BUDGET_W-1:0] csr_wr_data;
   int                  mismatch_count;
   int                  results_owed;
   bit                  stream_started;
   int                  burst_left;

   longest_window_k_replace_sliding DUT (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_letter    (req_letter),
      .req_last      (req_last),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_best_len  (rsp_best_len),
      .rsp_final_res (rsp_final_res),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data)
   );

   lwkr_checker score (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_letter     (req_letter),
      .req_last       (req_last),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_best_len   (rsp_best_len),
      .rsp_final_res  (rsp_final_res),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .mismatch_count (mismatch_count),
      .results_owed   (results_owed)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #2000000;
      $display("Regression FAIL");
      $finish;
   end

   // Receiver: random stall segments, plus one long hold once random traffic runs.
   initial begin
      int seg_left;
      int stall_pct;
      bit held;
      rsp_stall = 1'b0;
      seg_left  = 0;
      stall_pct = 0;
      held      = 1'b0;
      forever begin
         @(posedge clock);
         if (!held && stream_started) begin
            held = 1'b1;
            rsp_stall <= 1'b1;
            repeat ($urandom_range(60, 100)) @(posedge clock);
         end else begin
            if (seg_left == 0) begin
               seg_left = $urandom_range(8, 60);
               case ($urandom_range(3))
                  0: stall_pct = 0;
                  1: stall_pct = 25;
                  2: stall_pct = 50;
                  default: stall_pct = 85;
               endcase
            end
            seg_left--;
            rsp_stall <= ($urandom_range(99) < stall_pct);
         end
      end
   end

   task automatic send_beat(input logic [LETTER_W-1:0] code, input logic fin);
      req_valid  <= 1'b1;
      req_letter <= code;
      req_last   <= fin;
      do @(posedge clock); while (req_stall);
      burst_left--;
      if (burst_left <= 0) begin
         burst_left = $urandom_range(1, 40);
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   endtask

   // Drain everything owed, then write the budget.
   task automatic set_budget(input logic [BUDGET_W-1:0] k);
      req_valid <= 1'b0;
      @(posedge clock);
      while (results_owed != 0) @(posedge clock);
      repeat (3) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= k;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   task automatic send_string(input int len, input int alpha);
      int                  base;
      logic [LETTER_W-1:0] code;
      base = $urandom_range(0, ALPHABET - alpha);
      for (int i = 0; i < len; i++) begin
         if ($urandom_range(99) < 4)
            code = $urandom_range(1) ? LETTER_W'($urandom_range(0, 64))
                                     : LETTER_W'($urandom_range(91, 127));
         else
            code = LETTER_FIRST + LETTER_W'(base + $urandom_range(alpha - 1));
         send_beat(code, i == len - 1);
      end
   endtask

   task automatic send_mix(input int n_items);
      int sent;
      int len;
      int alpha;
      sent = 0;
      while (sent < n_items) begin
         len = $urandom_range(1, 25);
         if (len > n_items - sent) len = n_items - sent;
         case ($urandom_range(4))
            0: alpha = 1;
            1: alpha = 2;
            2: alpha = 3;
            3: alpha = 4;
            default: alpha = ALPHABET;
         endcase
         send_string(len, alpha);
         sent += len;
      end
   endtask

   initial begin
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_letter     = LETTER_FIRST;
      req_last       = 1'b0;
      csr_wr_en      = 1'b0;
      csr_wr_data    = '0;
      stream_started = 1'b0;
      burst_left     = $urandom_range(1, 40);
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // budget 0 out of reset: a second letter kind pushes the oldest out
      send_beat(CODE_A, 1'b0);
      send_beat(CODE_A, 1'b0);
      send_beat(CODE_B, 1'b1);
      send_beat(CODE_Z, 1'b1);
      // stray codes: no change, and last still closes the string
      send_beat(LETTER_W'(0), 1'b0);
      send_beat(LETTER_W'(127), 1'b1);
      send_beat(LETTER_W'(64), 1'b0);
      send_beat(CODE_C, 1'b0);
      send_beat(LETTER_W'(91), 1'b0);
      send_beat(CODE_C, 1'b1);

      set_budget(BUDGET_W'(2));
      send_beat(CODE_A, 1'b0);
      send_beat(CODE_Z, 1'b0);
      send_beat(CODE_A, 1'b0);
      send_beat(CODE_B, 1'b0);
      send_beat(CODE_A, 1'b0);
      send_beat(CODE_C, 1'b0);
      send_beat(CODE_A, 1'b1);

      // overrun the ring: best saturates at the window size
      set_budget(BUDGET_W'(256));
      stream_started = 1'b1;
      send_string(290, 3);

      set_budget(BUDGET_W'(0));
      send_mix(45);
      set_budget(BUDGET_W'(1));
      send_mix(45);
      set_budget(BUDGET_W'(2));
      send_mix(45);
      set_budget(BUDGET_W'(255));
      send_mix(45);
      set_budget(BUDGET_W'($urandom_range(3, 12)));
      send_mix(45);

      req_valid <= 1'b0;
      @(posedge clock);
      while (results_owed != 0) @(posedge clock);
      repeat (5) @(posedge clock);
      if (mismatch_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
